@@ design/gdc_pkg.sv @@
// Shared types and constants for the grid dimension calculator.
package gdc_pkg;

  localparam int COUNT_W   = 16;
  localparam int SQ_STEPS  = COUNT_W / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int SQ_REM_W  = ROOT_W + 1;
  localparam int DIV_STEPS = COUNT_W;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LIMIT    = CFG_IDX_W'(1);

  // Per-item control that rides along the whole chain.
  typedef struct packed {
    logic               invalid;
    logic               use_sqrt;
    logic               swap;
    logic [COUNT_W-1:0] fix;
    logic [COUNT_W-1:0] clamp;
  } gdc_side_t;

  // Beat held by one square root cell.
  typedef struct packed {
    logic [COUNT_W-1:0]  n;
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    gdc_side_t           side;
  } gdc_sq_t;

  // Beat held by one divide cell.
  typedef struct packed {
    logic [COUNT_W-1:0] n;
    logic [COUNT_W-1:0] d;
    logic [COUNT_W-1:0] rem;
    logic [COUNT_W-1:0] quo;
    gdc_side_t          side;
  } gdc_div_t;

endpackage

@@ design/gdc_sqrt_cell.sv @@
// One cell of the square root chain: settles one root bit per stage.
module gdc_sqrt_cell
  import gdc_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     vld_i,
  input  gdc_sq_t  dat_i,
  output logic     vld_o,
  output gdc_sq_t  dat_o
);

  localparam int LSB = COUNT_W - 2 * (STEP + 1);

  logic              vld_r;
  gdc_sq_t           dat_r;
  gdc_sq_t           dat_nxt;
  logic [SQ_REM_W+1:0] cur;
  logic [SQ_REM_W+1:0] trial;
  logic              ge;

  // Bring down two bits, then try to subtract 4*root + 1.
  always_comb begin
    cur     = {dat_i.rem, dat_i.n[LSB +: 2]};
    trial   = {1'b0, dat_i.root, 2'b01};
    ge      = (cur >= trial);
    dat_nxt = dat_i;
    dat_nxt.rem  = ge ? SQ_REM_W'(cur - trial) : SQ_REM_W'(cur);
    dat_nxt.root = {dat_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

@@ design/gdc_div_cell.sv @@
// One cell of the restoring divide chain: settles one quotient bit per stage.
module gdc_div_cell
  import gdc_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  logic     vld_i,
  input  gdc_div_t dat_i,
  output logic     vld_o,
  output gdc_div_t dat_o
);

  logic             vld_r;
  gdc_div_t         dat_r;
  gdc_div_t         dat_nxt;
  logic [COUNT_W:0] cur;
  logic             ge;

  always_comb begin
    cur     = {dat_i.rem, dat_i.n[BIT]};
    ge      = (cur >= {1'b0, dat_i.d});
    dat_nxt = dat_i;
    dat_nxt.rem = ge ? COUNT_W'(cur - {1'b0, dat_i.d}) : COUNT_W'(cur);
    dat_nxt.quo = {dat_i.quo[COUNT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dat_r <= dat_nxt;
    end
  end

  assign vld_o = vld_r;
  assign dat_o = dat_r;

endmodule

@@ design/grid_dimension_calc.sv @@
// Top level of the grid dimension calculator: decode, cell chains and output skid.
//
// The block takes one source count per beat and returns the columns and rows of a
// compositing grid, one result beat per input beat, in order. It accepts a new count
// on every cycle while the pipe is not halted; on its way to the output register each
// count passes one decode stage, a chain of 8 square root cells (one root bit
// per cell) and a chain of 16 restoring divide cells (one quotient bit per cell),
// after which the ceiling and limit clamp are applied on the way into the output
// register. The whole pipe advances together; it halts only while the skid
// register behind the output is occupied, so in_tready is a register output and
// does not depend combinationally on out_tready. Column and row limits are written
// through the cfg port (index 0 is the column limit, index 1 the row limit, other
// indexes are dropped); a limit of zero means that side is unlimited. Limits should
// only be changed while no count is in flight. A count of zero returns zero
// columns and rows with the invalid flag set.
module grid_dimension_calc
  import gdc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Input stream; tdata: source_count[15:0].
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [15:0]          in_tdata,
  // Result stream; tdata: grid_columns[15:0], grid_rows[31:16].
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,
  // tuser: invalid_count[0].
  output logic [0:0]           out_tuser,
  // Configuration writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COUNT_W-1:0]   cfg_data
);

  localparam logic [COUNT_W-1:0] NO_CLAMP = {COUNT_W{1'b1}};

  // Limit registers.
  logic [COUNT_W-1:0] column_limit_r;
  logic [COUNT_W-1:0] row_limit_r;

  // Pipe control: everything moves when the skid register is empty.
  logic adv;
  logic skid_valid_r;

  // Decode stage.
  logic      dec_valid_r;
  gdc_sq_t   dec_r;
  gdc_sq_t   dec_nxt;

  // Chains.
  logic      sq_vld [0:SQ_STEPS];
  gdc_sq_t   sq_dat [0:SQ_STEPS];
  logic      dv_vld [0:DIV_STEPS];
  gdc_div_t  dv_dat [0:DIV_STEPS];

  // Root to divider hand-off.
  logic [ROOT_W:0]    root_ceil;
  logic [COUNT_W-1:0] fix_sel;

  // Finishing logic and output registers.
  logic [COUNT_W:0]   quo_ceil;
  logic [COUNT_W-1:0] other_side;
  logic [31:0]        res_tdata;
  logic               res_invalid;
  logic               push;
  logic               out_fire;
  logic               out_valid_r;
  logic [31:0]        out_tdata_r;
  logic               out_tuser_r;
  logic [31:0]        skid_tdata_r;
  logic               skid_tuser_r;

  assign cfg_ready = 1'b1;
  assign adv       = !skid_valid_r;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_limit_r <= '0;
      row_limit_r    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLUMN_LIMIT: column_limit_r <= cfg_data;
        REG_ROW_LIMIT:    row_limit_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode picks the fixed side, which side it is, and the clamp on the other side.
  // Without limits (or with a single limit that already covers the count) the fixed
  // side is the ceiling square root, filled in after the root chain. With both
  // limits the smaller limit picks which side is fixed first; the case where the
  // limits are filled completely falls out of the clamp on the other side.
  always_comb begin
    dec_nxt               = '0;
    dec_nxt.n             = in_tdata;
    dec_nxt.side.invalid  = (in_tdata == '0);
    dec_nxt.side.clamp    = NO_CLAMP;
    if (column_limit_r == '0 && row_limit_r == '0) begin
      dec_nxt.side.use_sqrt = 1'b1;
    end else if (row_limit_r == '0) begin
      if (column_limit_r >= in_tdata) begin
        dec_nxt.side.use_sqrt = 1'b1;
      end else begin
        dec_nxt.side.fix = column_limit_r;
      end
    end else if (column_limit_r == '0) begin
      if (row_limit_r >= in_tdata) begin
        dec_nxt.side.use_sqrt = 1'b1;
      end else begin
        dec_nxt.side.fix  = row_limit_r;
        dec_nxt.side.swap = 1'b1;
      end
    end else if (row_limit_r >= column_limit_r) begin
      dec_nxt.side.fix   = (in_tdata < column_limit_r) ? in_tdata : column_limit_r;
      dec_nxt.side.clamp = row_limit_r;
    end else begin
      dec_nxt.side.fix   = (in_tdata < row_limit_r) ? in_tdata : row_limit_r;
      dec_nxt.side.clamp = column_limit_r;
      dec_nxt.side.swap  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_valid_r <= 1'b0;
    end else if (adv) begin
      dec_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dec_r <= dec_nxt;
    end
  end

  assign sq_vld[0] = dec_valid_r;
  assign sq_dat[0] = dec_r;

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    gdc_sqrt_cell #(.STEP(i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (sq_vld[i]),
      .dat_i (sq_dat[i]),
      .vld_o (sq_vld[i+1]),
      .dat_o (sq_dat[i+1])
    );
  end

  // The floor root is rounded up when the remainder is nonzero.
  always_comb begin
    root_ceil = {1'b0, sq_dat[SQ_STEPS].root} +
                (ROOT_W+1)'(sq_dat[SQ_STEPS].rem != '0);
    fix_sel   = sq_dat[SQ_STEPS].side.use_sqrt ? COUNT_W'(root_ceil)
                                               : sq_dat[SQ_STEPS].side.fix;
    dv_dat[0]          = '0;
    dv_dat[0].n        = sq_dat[SQ_STEPS].n;
    dv_dat[0].d        = fix_sel;
    dv_dat[0].side     = sq_dat[SQ_STEPS].side;
    dv_dat[0].side.fix = fix_sel;
  end
  assign dv_vld[0] = sq_vld[SQ_STEPS];

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    gdc_div_cell #(.BIT(DIV_STEPS - 1 - i)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .vld_i (dv_vld[i]),
      .dat_i (dv_dat[i]),
      .vld_o (dv_vld[i+1]),
      .dat_o (dv_dat[i+1])
    );
  end

  // Ceiling of the quotient, clamp, and placement of the two sides.
  always_comb begin
    quo_ceil    = {1'b0, dv_dat[DIV_STEPS].quo} +
                  (COUNT_W+1)'(dv_dat[DIV_STEPS].rem != '0);
    other_side  = (quo_ceil > {1'b0, dv_dat[DIV_STEPS].side.clamp})
                  ? dv_dat[DIV_STEPS].side.clamp : COUNT_W'(quo_ceil);
    res_invalid = dv_dat[DIV_STEPS].side.invalid;
    if (res_invalid) begin
      res_tdata = '0;
    end else if (dv_dat[DIV_STEPS].side.swap) begin
      res_tdata = {dv_dat[DIV_STEPS].side.fix, other_side};
    end else begin
      res_tdata = {other_side, dv_dat[DIV_STEPS].side.fix};
    end
  end

  // Output register with a skid register behind it.
  assign push     = adv && dv_vld[DIV_STEPS];
  assign out_fire = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_tdata_r <= skid_tdata_r;
        out_tuser_r <= skid_tuser_r;
      end
    end else if (push) begin
      if (out_valid_r && !out_tready) begin
        skid_tdata_r <= res_tdata;
        skid_tuser_r <= res_invalid;
      end else begin
        out_tdata_r <= res_tdata;
        out_tuser_r <= res_invalid;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

`ifndef SYNTH
  // The skid register only holds a beat while the output register is full.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register holds a beat while the output is empty");

  // The skid register fills only after a stalled output cycle.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled without an output stall");

  // A zero count gives an all-zero grid.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tuser_r) |-> (out_tdata_r == '0))
    else $error("invalid count returned a nonzero grid");

  // A valid count always gives at least one column and one row.
  a_grid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tuser_r) |->
      (out_tdata_r[15:0] != '0 && out_tdata_r[31:16] != '0))
    else $error("valid count returned an empty side");
`endif

endmodule
